@@ rtl/core/rhk_pkg.sv @@
// ----------------------------------------------------------------------------
// rhk_pkg
// Shared types, codes and constants for the humidity knob controller.
// ----------------------------------------------------------------------------
`default_nettype none

package rhk_pkg;

   // Field widths
   localparam int CODE_W    = 24;
   localparam int HUM_W     = 7;
   localparam int STEPS_W   = 12;
   localparam int MOVE_W    = 13;
   localparam int BAND_W    = 4;
   localparam int GOAL_W    = 7;
   localparam int DIGIT_W   = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 12;

   // Remote button codes
   localparam logic [CODE_W-1:0] CODE_POWER = 24'hFFA25D;
   localparam logic [CODE_W-1:0] CODE_FUNC  = 24'hFFE21D;
   localparam logic [CODE_W-1:0] CODE_BACK  = 24'hFF22DD;
   localparam logic [CODE_W-1:0] CODE_NEXT  = 24'hFFC23D;

   localparam int NUM_DIGITS = 10;
   localparam logic [CODE_W-1:0] DIGIT_CODES [NUM_DIGITS] = '{
      24'hFF6897, 24'hFF30CF, 24'hFF18E7, 24'hFF7A85, 24'hFF10EF,
      24'hFF38C7, 24'hFF5AA5, 24'hFF42BD, 24'hFF4AB5, 24'hFF52AD
   };

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POWER_ON_STEPS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAVEL_STEPS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_BAND     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_ON_BAND   = 2'd3;

   // Register reset values
   localparam logic [STEPS_W-1:0] POWER_ON_STEPS_RESET = 12'd245;
   localparam logic [STEPS_W-1:0] TRAVEL_STEPS_RESET   = 12'd1653;
   localparam logic [BAND_W-1:0]  UPPER_BAND_RESET     = 4'd2;
   localparam logic [HUM_W-1:0]   FULL_ON_BAND_RESET   = 7'd10;

   // Steps per percent: travel / 100 by reciprocal multiply, exact below 4096
   localparam int PCT_SCALE   = 100;
   localparam int PIECE_W     = 6;
   localparam int PIECE_SHIFT = 19;
   localparam int PIECE_RECIP = ((1 << PIECE_SHIFT) + PCT_SCALE - 1) / PCT_SCALE;
   localparam int PIECE_PROD_W = STEPS_W + PIECE_SHIFT - 6;
   localparam logic [PIECE_W-1:0] PIECE_RESET = PIECE_W'(TRAVEL_STEPS_RESET / PCT_SCALE);

   localparam logic [HUM_W-1:0] PCT_FULL = 7'd100;
   localparam logic [HUM_W-1:0] PCT_ONE  = 7'd1;

   // Queue depths
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 4;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_POWER,
      OP_FUNC,
      OP_BACK,
      OP_NEXT,
      OP_DIGIT,
      OP_SAMPLE
   } op_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_PCT,
      ACT_ON,
      ACT_OFF
   } act_type;

   typedef enum logic [0:0] {
      ST_PLAN,
      ST_APPLY
   } exec_state_type;

   typedef struct packed {
      op_type           op;
      logic [HUM_W-1:0] val;
   } cmd_type;

   typedef struct packed {
      logic [STEPS_W-1:0] power_on_steps;
      logic [STEPS_W-1:0] travel_steps;
      logic [BAND_W-1:0]  upper_band;
      logic [HUM_W-1:0]   full_on_band;
      logic [PIECE_W-1:0] piece;
   } cfg_type;

   typedef struct packed {
      logic                     has_move;
      logic signed [MOVE_W-1:0] move_steps;
      logic                     last_of_run;
      logic                     powered;
      logic [STEPS_W-1:0]       knob_position;
      logic [GOAL_W-1:0]        goal_percent;
      logic                     entry_mode;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/core/remote_humidity_knob_controller_unit.sv @@
// ----------------------------------------------------------------------------
// remote_humidity_knob_controller_unit
// Remote code and humidity sample driven stepper knob controller.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake        | Contents
//  req_     | in        | valid / ready    | kind, button code, humidity
//  rsp_     | out       | valid / ready    | move, last mark, status
//  csr_     | in        | write enable     | 4 registers, 12-bit data
//
//  Each transaction is decoded on acceptance into a 2-entry command queue.
//  The executor takes a command in plan (percent and target multiply), then
//  apply (clamp, move, results), and only then plans the next command.
//  Results (1 or 2) go into a 4-entry queue; apply waits for 2 free slots.
//  Synchronous active-high reset clears control state and loads CSR defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module remote_humidity_knob_controller_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_kind,
   input  wire logic [rhk_pkg::CODE_W-1:0]           req_button_code,
   input  wire logic [rhk_pkg::HUM_W-1:0]            req_humidity,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_has_move,
   output logic signed [rhk_pkg::MOVE_W-1:0]         rsp_move_steps,
   output logic                                      rsp_last_of_run,
   output logic                                      rsp_powered,
   output logic [rhk_pkg::STEPS_W-1:0]               rsp_knob_position,
   output logic [rhk_pkg::GOAL_W-1:0]                rsp_goal_percent,
   output logic                                      rsp_entry_mode,
   input  wire logic                                 csr_we,
   input  wire logic [rhk_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [rhk_pkg::CSR_DAT_W-1:0]        csr_wdata
);

   logic [rhk_pkg::STEPS_W-1:0] pow_ff, travel_ff;
   logic [rhk_pkg::BAND_W-1:0]  upper_ff;
   logic [rhk_pkg::HUM_W-1:0]   fob_ff;
   logic [rhk_pkg::PIECE_W-1:0] piece_ff, piece_in;
   logic [rhk_pkg::PIECE_PROD_W+5:0] piece_prod;

   rhk_pkg::cfg_type cfg;
   rhk_pkg::cmd_type cmd;
   rhk_pkg::rsp_type rsp0, rsp1, rsp_head;
   logic cmd_valid, cmd_pop, rsp_room, rsp_push, rsp_two;

   always_ff @(posedge clock) begin
      if (reset) begin
         pow_ff    <= rhk_pkg::POWER_ON_STEPS_RESET;
         travel_ff <= rhk_pkg::TRAVEL_STEPS_RESET;
         upper_ff  <= rhk_pkg::UPPER_BAND_RESET;
         fob_ff    <= rhk_pkg::FULL_ON_BAND_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rhk_pkg::CSR_POWER_ON_STEPS: pow_ff    <= csr_wdata;
            rhk_pkg::CSR_TRAVEL_STEPS:   travel_ff <= csr_wdata;
            rhk_pkg::CSR_UPPER_BAND:     upper_ff  <= csr_wdata[rhk_pkg::BAND_W-1:0];
            rhk_pkg::CSR_FULL_ON_BAND:   fob_ff    <= csr_wdata[rhk_pkg::HUM_W-1:0];
            default:                     pow_ff    <= pow_ff;
         endcase
      end
   end

   // steps per percent, follows travel in the next cycle
   assign piece_prod = {{(rhk_pkg::PIECE_PROD_W + 6 - rhk_pkg::STEPS_W){1'b0}}, travel_ff}
                     * (rhk_pkg::PIECE_PROD_W + 6)'(rhk_pkg::PIECE_RECIP);
   assign piece_in   = piece_prod[rhk_pkg::PIECE_SHIFT +: rhk_pkg::PIECE_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         piece_ff <= rhk_pkg::PIECE_RESET;
      end else begin
         piece_ff <= piece_in;
      end
   end

   always_comb begin
      cfg.power_on_steps = pow_ff;
      cfg.travel_steps   = travel_ff;
      cfg.upper_band     = upper_ff;
      cfg.full_on_band   = fob_ff;
      cfg.piece          = piece_ff;
   end

   rhk_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_button_code (req_button_code),
      .req_humidity    (req_humidity),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   rhk_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_room  (rsp_room),
      .rsp_push  (rsp_push),
      .rsp_two   (rsp_two),
      .rsp0      (rsp0),
      .rsp1      (rsp1)
   );

   rhk_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_two  (rsp_two),
      .din0      (rsp0),
      .din1      (rsp1),
      .room      (rsp_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dout      (rsp_head)
   );

   assign rsp_has_move      = rsp_head.has_move;
   assign rsp_move_steps    = rsp_head.move_steps;
   assign rsp_last_of_run   = rsp_head.last_of_run;
   assign rsp_powered       = rsp_head.powered;
   assign rsp_knob_position = rsp_head.knob_position;
   assign rsp_goal_percent  = rsp_head.goal_percent;
   assign rsp_entry_mode    = rsp_head.entry_mode;

endmodule

`default_nettype wire

@@ rtl/core/rhk_front.sv @@
// ----------------------------------------------------------------------------
// rhk_front
// Decodes incoming transactions into commands and queues them for execution.
// ----------------------------------------------------------------------------
`default_nettype none

module rhk_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_kind,
   input  wire logic [rhk_pkg::CODE_W-1:0]    req_button_code,
   input  wire logic [rhk_pkg::HUM_W-1:0]     req_humidity,
   output logic                               cmd_valid,
   output rhk_pkg::cmd_type                   cmd,
   input  wire logic                          cmd_pop
);

   localparam int PTR_W = $clog2(rhk_pkg::CMD_DEPTH);
   localparam int CNT_W = $clog2(rhk_pkg::CMD_DEPTH + 1);

   rhk_pkg::cmd_type dec;
   rhk_pkg::cmd_type slot_ff [rhk_pkg::CMD_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;

   always_comb begin
      dec.op  = rhk_pkg::OP_NONE;
      dec.val = '0;
      if (req_kind) begin
         dec.op  = rhk_pkg::OP_SAMPLE;
         dec.val = req_humidity;
      end else if (req_button_code == rhk_pkg::CODE_POWER) begin
         dec.op = rhk_pkg::OP_POWER;
      end else if (req_button_code == rhk_pkg::CODE_FUNC) begin
         dec.op = rhk_pkg::OP_FUNC;
      end else if (req_button_code == rhk_pkg::CODE_BACK) begin
         dec.op = rhk_pkg::OP_BACK;
      end else if (req_button_code == rhk_pkg::CODE_NEXT) begin
         dec.op = rhk_pkg::OP_NEXT;
      end else begin
         for (int i = 0; i < rhk_pkg::NUM_DIGITS; i++) begin
            if (req_button_code == rhk_pkg::DIGIT_CODES[i]) begin
               dec.op  = rhk_pkg::OP_DIGIT;
               dec.val = rhk_pkg::HUM_W'(i);
            end
         end
      end
   end

   assign req_ready = (count_ff != CNT_W'(rhk_pkg::CMD_DEPTH));
   assign push      = req_valid & req_ready;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push    ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/rhk_exec.sv @@
// ----------------------------------------------------------------------------
// rhk_exec
// Executes queued commands: plans the percent target, then applies the knob
// move and emits one or two results.
// ----------------------------------------------------------------------------
`default_nettype none

module rhk_exec (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rhk_pkg::cfg_type  cfg,
   input  wire logic              cmd_valid,
   input  wire rhk_pkg::cmd_type  cmd,
   output logic                   cmd_pop,
   input  wire logic              rsp_room,
   output logic                   rsp_push,
   output logic                   rsp_two,
   output rhk_pkg::rsp_type       rsp0,
   output rhk_pkg::rsp_type       rsp1
);

   localparam int PROD_W = rhk_pkg::PIECE_W + rhk_pkg::HUM_W;

   rhk_pkg::exec_state_type state_ff, state_in;
   logic apply_go;

   // Architectural state
   logic [rhk_pkg::GOAL_W-1:0]  goal_ff, goal_in;
   logic [rhk_pkg::DIGIT_W-1:0] first_ff, first_in;
   logic                        digit_idx_ff, digit_idx_in;
   logic                        entry_ff, entry_in;
   logic                        user_on_ff, user_on_in;
   logic                        auto_off_ff, auto_off_in;
   logic [rhk_pkg::STEPS_W-1:0] pos_ff, pos_in;
   logic                        reached_ff, reached_in;

   // Plan to apply handoff
   rhk_pkg::act_type            act_ff, act_in;
   logic                        p_zero_ff, p_zero_in;
   logic [rhk_pkg::STEPS_W-1:0] target_ff, target_in;

   // Plan datapath
   logic [rhk_pkg::HUM_W-1:0]  p_plan;
   logic [rhk_pkg::HUM_W:0]    goal_plus_ub;
   logic [rhk_pkg::HUM_W:0]    hum_plus_fob;
   logic [rhk_pkg::HUM_W-1:0]  goal_minus_hum;
   logic [rhk_pkg::HUM_W-1:0]  digit_pct;
   logic [rhk_pkg::GOAL_W-1:0] digit_goal;
   logic [PROD_W-1:0]          target_prod;
   logic                       reached_tmp;

   // Apply datapath
   logic signed [rhk_pkg::MOVE_W-1:0] pow_pos, pow_neg, pos_neg, mv;
   logic signed [rhk_pkg::MOVE_W-1:0] c0, c1, c2, m_first, m_second;
   logic [rhk_pkg::STEPS_W-1:0]       new_pos;
   logic                              v0, v1, v2, any_move, two_moves;

   // ---------------- FSM ----------------
   always_comb begin
      case (state_ff)
         rhk_pkg::ST_PLAN:  state_in = cmd_valid ? rhk_pkg::ST_APPLY : rhk_pkg::ST_PLAN;
         rhk_pkg::ST_APPLY: state_in = rsp_room  ? rhk_pkg::ST_PLAN  : rhk_pkg::ST_APPLY;
         default:           state_in = rhk_pkg::ST_PLAN;
      endcase
   end

   always_comb begin
      cmd_pop  = 1'b0;
      apply_go = 1'b0;
      case (state_ff)
         rhk_pkg::ST_PLAN:  cmd_pop  = cmd_valid;
         rhk_pkg::ST_APPLY: apply_go = rsp_room;
         default: begin
            cmd_pop  = 1'b0;
            apply_go = 1'b0;
         end
      endcase
   end

   // ---------------- Plan ----------------
   assign goal_plus_ub   = {1'b0, goal_ff} + {4'b0, cfg.upper_band};
   assign hum_plus_fob   = {1'b0, cmd.val} + {1'b0, cfg.full_on_band};
   assign goal_minus_hum = goal_ff - cmd.val;
   assign digit_pct      = {cmd.val[3:0], 3'b0} + {2'b0, cmd.val[3:0], 1'b0};
   assign digit_goal     = {first_ff, 3'b0} + {2'b0, first_ff, 1'b0}
                         + {3'b0, cmd.val[3:0]};

   always_comb begin
      goal_in       = goal_ff;
      first_in      = first_ff;
      digit_idx_in  = digit_idx_ff;
      entry_in      = entry_ff;
      reached_in    = reached_ff;
      act_in        = rhk_pkg::ACT_NONE;
      p_plan        = '0;
      reached_tmp   = reached_ff;
      case (cmd.op)
         rhk_pkg::OP_POWER: begin
            act_in = user_on_ff ? rhk_pkg::ACT_OFF : rhk_pkg::ACT_ON;
         end
         rhk_pkg::OP_FUNC: begin
            entry_in = !entry_ff;
         end
         rhk_pkg::OP_BACK: begin
            if (entry_ff) begin
               digit_idx_in = 1'b0;
            end else begin
               act_in = rhk_pkg::ACT_PCT;
            end
         end
         rhk_pkg::OP_NEXT: begin
            if (entry_ff) begin
               entry_in = 1'b0;
            end else begin
               act_in = rhk_pkg::ACT_PCT;
               p_plan = rhk_pkg::PCT_FULL;
            end
         end
         rhk_pkg::OP_DIGIT: begin
            if (entry_ff) begin
               if (!digit_idx_ff) begin
                  first_in     = cmd.val[3:0];
                  digit_idx_in = 1'b1;
               end else begin
                  goal_in      = digit_goal;
                  digit_idx_in = 1'b0;
               end
            end else begin
               act_in = rhk_pkg::ACT_PCT;
               p_plan = digit_pct;
            end
         end
         rhk_pkg::OP_SAMPLE: begin
            if (!entry_ff && (goal_ff != '0) && user_on_ff) begin
               // hysteresis: clear below goal, set at goal plus band
               if (reached_tmp && (cmd.val < goal_ff)) begin
                  reached_tmp = 1'b0;
               end
               if (!reached_tmp && ({1'b0, cmd.val} >= goal_plus_ub)) begin
                  reached_tmp = 1'b1;
               end
               reached_in = reached_tmp;
               act_in     = rhk_pkg::ACT_PCT;
               if (reached_tmp) begin
                  p_plan = '0;
               end else if (cmd.val >= goal_ff) begin
                  p_plan = rhk_pkg::PCT_ONE;
               end else if (hum_plus_fob < {1'b0, goal_ff}) begin
                  p_plan = rhk_pkg::PCT_FULL;
               end else if (goal_minus_hum > rhk_pkg::PCT_FULL) begin
                  p_plan = rhk_pkg::PCT_FULL;
               end else begin
                  p_plan = goal_minus_hum;
               end
            end
         end
         default: begin
            act_in = rhk_pkg::ACT_NONE;
         end
      endcase
   end

   assign target_prod = {{rhk_pkg::HUM_W{1'b0}}, cfg.piece} * {{rhk_pkg::PIECE_W{1'b0}}, p_plan};
   assign target_in   = target_prod[rhk_pkg::STEPS_W-1:0];
   assign p_zero_in   = (p_plan == '0);

   // ---------------- Apply ----------------
   assign pow_pos = signed'({1'b0, cfg.power_on_steps});
   assign pow_neg = -pow_pos;
   assign pos_neg = -signed'({1'b0, pos_ff});
   assign new_pos = (target_ff > cfg.travel_steps) ? cfg.travel_steps : target_ff;
   assign mv      = signed'({1'b0, new_pos}) - signed'({1'b0, pos_ff});

   always_comb begin
      c0          = '0;
      c1          = '0;
      c2          = '0;
      pos_in      = pos_ff;
      user_on_in  = user_on_ff;
      auto_off_in = auto_off_ff;
      case (act_ff)
         rhk_pkg::ACT_ON: begin
            c0         = pow_pos;
            pos_in     = '0;
            user_on_in = 1'b1;
         end
         rhk_pkg::ACT_OFF: begin
            c1         = pos_neg;
            c2         = pow_neg;
            pos_in     = '0;
            user_on_in = 1'b0;
         end
         rhk_pkg::ACT_PCT: begin
            // ignore when off, or a zero request while already soft off
            if (user_on_ff && !(auto_off_ff && p_zero_ff)) begin
               if (auto_off_ff) begin
                  c0 = pow_pos;
               end
               c1     = mv;
               pos_in = new_pos;
               if (p_zero_ff) begin
                  c2          = pow_neg;
                  auto_off_in = 1'b1;
               end else begin
                  auto_off_in = 1'b0;
               end
            end
         end
         default: begin
            c0 = '0;
         end
      endcase
   end

   // drop zero-length moves and pack the rest
   always_comb begin
      v0        = (c0 != '0);
      v1        = (c1 != '0);
      v2        = (c2 != '0);
      any_move  = v0 | v1 | v2;
      two_moves = (v0 & v1) | (v0 & v2) | (v1 & v2);
      m_first   = v0 ? c0 : (v1 ? c1 : c2);
      m_second  = (v0 & v1) ? c1 : c2;
   end

   always_comb begin
      rsp0.has_move      = any_move;
      rsp0.move_steps    = any_move ? m_first : '0;
      rsp0.last_of_run   = !two_moves;
      rsp0.powered       = user_on_in;
      rsp0.knob_position = pos_in;
      rsp0.goal_percent  = goal_ff;
      rsp0.entry_mode    = entry_ff;
      rsp1               = rsp0;
      rsp1.move_steps    = m_second;
      rsp1.last_of_run   = 1'b1;
   end

   assign rsp_push = apply_go;
   assign rsp_two  = apply_go & two_moves;

   // ---------------- Registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rhk_pkg::ST_PLAN;
         goal_ff      <= '0;
         first_ff     <= '0;
         digit_idx_ff <= 1'b0;
         entry_ff     <= 1'b0;
         user_on_ff   <= 1'b0;
         auto_off_ff  <= 1'b0;
         pos_ff       <= '0;
         reached_ff   <= 1'b0;
         act_ff       <= rhk_pkg::ACT_NONE;
      end else begin
         state_ff <= state_in;
         if (cmd_pop) begin
            goal_ff      <= goal_in;
            first_ff     <= first_in;
            digit_idx_ff <= digit_idx_in;
            entry_ff     <= entry_in;
            reached_ff   <= reached_in;
            act_ff       <= act_in;
         end
         if (apply_go) begin
            user_on_ff  <= user_on_in;
            auto_off_ff <= auto_off_in;
            pos_ff      <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         p_zero_ff <= p_zero_in;
         target_ff <= target_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/rhk_rsp_fifo.sv @@
// ----------------------------------------------------------------------------
// rhk_rsp_fifo
// Result queue: takes 1 or 2 results a cycle, delivers one a cycle when ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rhk_rsp_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic              push_two,
   input  wire rhk_pkg::rsp_type  din0,
   input  wire rhk_pkg::rsp_type  din1,
   output logic                   room,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rhk_pkg::rsp_type       dout
);

   localparam int PTR_W = $clog2(rhk_pkg::RSP_DEPTH);
   localparam int CNT_W = $clog2(rhk_pkg::RSP_DEPTH + 1);

   rhk_pkg::rsp_type slot_ff [rhk_pkg::RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign rsp_valid = (count_ff != '0);
   assign dout      = slot_ff[rd_ptr_ff];
   assign pop       = rsp_valid & rsp_ready;
   // the writer must write only when two slots are free; not enforced here
   assign room      = (count_ff <= CNT_W'(rhk_pkg::RSP_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push) + PTR_W'(push_two);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push) + CNT_W'(push_two) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= din0;
      end
      if (push_two) begin
         slot_ff[wr_ptr_ff + PTR_W'(1)] <= din1;
      end
   end

endmodule

`default_nettype wire
